### rtl/core/rational_fraction_alu_unit_defines.svh
// Assertion macros shared by the fraction ALU RTL.
`ifndef RATIONAL_FRACTION_ALU_UNIT_DEFINES_SVH
`define RATIONAL_FRACTION_ALU_UNIT_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define RFA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define RFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

### rtl/core/rfa_pkg.sv
// Package: opcodes, state types and queue word for the fraction ALU.
`default_nettype none
package rfa_pkg;
  localparam int unsigned OpW = 2;
  localparam int unsigned FieldW = 32;

  typedef enum logic [1:0] {
    OP_MUL  = 2'd0,
    OP_ADD  = 2'd1,
    OP_SIMP = 2'd2,
    OP_QUOT = 2'd3
  } op_t;

  // Class tags assigned by the front end.
  typedef enum logic [1:0] {
    CL_MUL    = 2'd0,
    CL_ADDEQ  = 2'd1,
    CL_ADDLCM = 2'd2,
    CL_DIV    = 2'd3
  } cls_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_GCD,
    ST_GCD_WAIT,
    ST_L_DIV,
    ST_L_MUL,
    ST_S1_DIV,
    ST_S1_MUL,
    ST_S2_DIV,
    ST_S2_MUL,
    ST_SN_DIV,
    ST_SD_DIV,
    ST_Q_DIV,
    ST_DONE
  } be_state_t;

  typedef struct packed {
    cls_t              cls;
    logic [OpW-1:0]    op;
    logic [FieldW-1:0] a_num;
    logic [FieldW-1:0] a_den;
    logic [FieldW-1:0] b_num;
    logic [FieldW-1:0] b_den;
  } fe_word_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;
endpackage
`default_nettype wire

### rtl/core/rfa_if.sv
// Valid/ready channel interface carrying one payload word.
`default_nettype none
interface rfa_if #(parameter type payload_t = logic) (input wire logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/core/rfa_front.sv
// Front end: takes input words, classifies them, feeds the queue.
`default_nettype none
module rfa_front #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [1:0]                   in_op,
  input  wire logic [rfa_pkg::FieldW-1:0]   in_a_num,
  input  wire logic [rfa_pkg::FieldW-1:0]   in_a_den,
  input  wire logic [rfa_pkg::FieldW-1:0]   in_b_num,
  input  wire logic [rfa_pkg::FieldW-1:0]   in_b_den,
  output logic                              q_valid,
  input  wire logic                         q_ready,
  output rfa_pkg::fe_word_t                 q_word
);
  import rfa_pkg::*;

  // Two-entry queue between front and back.
  fe_word_t  mem_r [2];
  logic      wp_r, rp_r, wp_nxt, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  fe_word_t  w;
  logic [DATA_WIDTH-1:0] ad_w, bd_w;
  logic push, pop;

  // Denominator compare at the working width.
  assign ad_w = DATA_WIDTH'(in_a_den);
  assign bd_w = DATA_WIDTH'(in_b_den);

  always_comb begin
    w.op    = in_op;
    w.a_num = in_a_num;
    w.a_den = in_a_den;
    w.b_num = in_b_num;
    w.b_den = in_b_den;
    case (op_t'(in_op))
      OP_MUL:  w.cls = CL_MUL;
      OP_ADD:  w.cls = (ad_w == bd_w) ? CL_ADDEQ : CL_ADDLCM;
      default: w.cls = CL_DIV;
    endcase
  end

  assign in_ready = rst_n && (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_word   = mem_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= w;
    end
  end
endmodule
`default_nettype wire

### rtl/core/rfa_divider.sv
// Signed restoring divider, one quotient bit per cycle, C truncation.
`default_nettype none
module rfa_divider #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [DATA_WIDTH-1:0] dividend,
  input  wire logic [DATA_WIDTH-1:0] divisor,
  output logic                       busy,
  output logic                       done,
  output logic [DATA_WIDTH-1:0]      quot,
  output logic [DATA_WIDTH-1:0]      rem
);
  localparam int unsigned CntW = $clog2(DATA_WIDTH + 1);

  logic [DATA_WIDTH-1:0] q_r, q_nxt, d_r, d_nxt;
  logic [DATA_WIDTH:0]   r_r, r_nxt, trial;
  logic [CntW-1:0]       cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt, qneg_r, rneg_r;
  logic [DATA_WIDTH-1:0] mx, my;

  assign mx = dividend[DATA_WIDTH-1] ? -dividend : dividend;
  assign my = divisor[DATA_WIDTH-1] ? -divisor : divisor;
  assign trial = {r_r[DATA_WIDTH-1:0], q_r[DATA_WIDTH-1]} - {1'b0, d_r};

  always_comb begin
    q_nxt = q_r;
    r_nxt = r_r;
    d_nxt = d_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt = mx;
      r_nxt = '0;
      d_nxt = my;
      cnt_nxt = CntW'(DATA_WIDTH);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[DATA_WIDTH]) begin
        r_nxt = trial;
        q_nxt = {q_r[DATA_WIDTH-2:0], 1'b1};
      end else begin
        r_nxt = {r_r[DATA_WIDTH-1:0], q_r[DATA_WIDTH-1]};
        q_nxt = {q_r[DATA_WIDTH-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CntW'(1);
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    r_r <= r_nxt;
    d_r <= d_nxt;
    if (start) begin
      qneg_r <= dividend[DATA_WIDTH-1] ^ divisor[DATA_WIDTH-1];
      rneg_r <= dividend[DATA_WIDTH-1];
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = qneg_r ? -q_r : q_r;
  assign rem  = rneg_r ? -r_r[DATA_WIDTH-1:0] : r_r[DATA_WIDTH-1:0];
endmodule
`default_nettype wire

### rtl/core/rfa_back.sv
// Back end: sequencer running multiply, gcd, lcm and quotient steps.
`default_nettype none
module rfa_back #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        q_valid,
  output logic                             q_ready,
  input  wire rfa_pkg::fe_word_t           q_word,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [rfa_pkg::FieldW-1:0]       out_res_num,
  output logic [rfa_pkg::FieldW-1:0]       out_res_den,
  output logic                             out_status,
  output rfa_pkg::div_ctl_t                dctl
);
  import rfa_pkg::*;
  localparam int unsigned W = DATA_WIDTH;

  be_state_t st_r, st_nxt;
  logic [W-1:0] an_r, ad_r, bn_r, bd_r, hi_r, lo_r, l_r, s1_r, t_r, rn_r, rd_r;
  cls_t         cls_r;
  logic         flt_r;
  logic [W-1:0] ddnd, dsor, dq, drem;
  logic         dstart, dbusy, ddone;
  logic [FieldW-1:0] on_r, od_r;
  logic ost_r, ov_r;
  logic take, div0, slt_ab, slt_nd;

  rfa_divider #(.DATA_WIDTH(W)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dstart), .dividend(ddnd), .divisor(dsor),
    .busy(dbusy), .done(ddone), .quot(dq), .rem(drem)
  );

  assign dctl.start = dstart;
  assign dctl.busy  = dbusy;
  assign dctl.done  = ddone;

  // Sign-extend-then-wrap of a 32-bit field to W bits.
  function automatic logic [W-1:0] fw(input logic [FieldW-1:0] v);
    logic [63:0] e;
    e = {{32{v[FieldW-1]}}, v};
    return e[W-1:0];
  endfunction

  function automatic logic [FieldW-1:0] ow(input logic [W-1:0] v);
    logic [63:0] e;
    e = 64'($signed(v));
    return e[FieldW-1:0];
  endfunction

  assign q_ready = (st_r == ST_IDLE);
  assign take    = q_valid && q_ready;
  assign slt_ab  = $signed(fw(q_word.a_den)) < $signed(fw(q_word.b_den));
  assign slt_nd  = $signed(fw(q_word.a_num)) < $signed(fw(q_word.a_den));
  assign div0    = (dsor == '0);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (take) begin
          case (q_word.cls)
            CL_MUL:    st_nxt = ST_MUL;
            CL_ADDEQ:  st_nxt = ST_DONE;
            CL_ADDLCM: st_nxt = ST_GCD;
            default:   st_nxt = (op_t'(q_word.op) == OP_QUOT) ? ST_Q_DIV : ST_GCD;
          endcase
        end
      end
      ST_MUL:      st_nxt = ST_DONE;
      ST_GCD:      st_nxt = div0 ? ST_DONE : ST_GCD_WAIT;
      ST_GCD_WAIT: begin
        if (ddone) begin
          if (drem != '0) begin
            st_nxt = ST_GCD;
          end else if (cls_r == CL_ADDLCM) begin
            st_nxt = ST_L_DIV;
          end else begin
            st_nxt = ST_SN_DIV;
          end
        end
      end
      ST_L_DIV:  st_nxt = ddone ? ST_L_MUL : ST_L_DIV;
      ST_L_MUL:  st_nxt = ST_S1_DIV;
      ST_S1_DIV: st_nxt = (div0 && !dbusy) ? ST_DONE : (ddone ? ST_S1_MUL : ST_S1_DIV);
      ST_S1_MUL: st_nxt = ST_S2_DIV;
      ST_S2_DIV: st_nxt = (div0 && !dbusy) ? ST_DONE : (ddone ? ST_S2_MUL : ST_S2_DIV);
      ST_S2_MUL: st_nxt = ST_DONE;
      ST_SN_DIV: st_nxt = ddone ? ST_SD_DIV : ST_SN_DIV;
      ST_SD_DIV: st_nxt = ddone ? ST_DONE : ST_SD_DIV;
      ST_Q_DIV:  st_nxt = (div0 && !dbusy) ? ST_DONE : (ddone ? ST_DONE : ST_Q_DIV);
      ST_DONE:   st_nxt = (!ov_r || out_ready) ? ST_IDLE : ST_DONE;
      default:   st_nxt = ST_IDLE;
    endcase
  end

  // Divider operand select and start strobe.
  always_comb begin
    ddnd = hi_r;
    dsor = lo_r;
    dstart = 1'b0;
    case (st_r)
      ST_GCD:    begin ddnd = hi_r; dsor = lo_r; dstart = !div0; end
      ST_L_DIV:  begin ddnd = hi_r; dsor = lo_r; dstart = !dbusy && !ddone; end
      ST_S1_DIV: begin ddnd = l_r; dsor = ad_r; dstart = !dbusy && !ddone && !div0; end
      ST_S2_DIV: begin ddnd = l_r; dsor = bd_r; dstart = !dbusy && !ddone && !div0; end
      ST_SN_DIV: begin ddnd = an_r; dsor = lo_r; dstart = !dbusy && !ddone; end
      ST_SD_DIV: begin ddnd = ad_r; dsor = lo_r; dstart = !dbusy && !ddone; end
      ST_Q_DIV:  begin ddnd = an_r; dsor = ad_r; dstart = !dbusy && !ddone && !div0; end
      default:   begin ddnd = hi_r; dsor = lo_r; dstart = 1'b0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      ov_r <= 1'b0;
      flt_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_DONE && (!ov_r || out_ready)) begin
        ov_r <= 1'b1;
      end else if (ov_r && out_ready) begin
        ov_r <= 1'b0;
      end
      if (take) begin
        flt_r <= 1'b0;
      end else if ((st_r == ST_GCD || st_r == ST_S1_DIV || st_r == ST_S2_DIV ||
                    st_r == ST_Q_DIV) && div0 && !dbusy && !ddone) begin
        flt_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cls_r <= q_word.cls;
      an_r  <= fw(q_word.a_num);
      ad_r  <= fw(q_word.a_den);
      bn_r  <= fw(q_word.b_num);
      bd_r  <= fw(q_word.b_den);
      s1_r  <= '0;
      if (q_word.cls == CL_ADDLCM) begin
        hi_r <= slt_ab ? fw(q_word.b_den) : fw(q_word.a_den);
        lo_r <= slt_ab ? fw(q_word.a_den) : fw(q_word.b_den);
      end else begin
        hi_r <= slt_nd ? fw(q_word.a_den) : fw(q_word.a_num);
        lo_r <= slt_nd ? fw(q_word.a_num) : fw(q_word.a_den);
      end
      if (q_word.cls == CL_ADDEQ) begin
        rn_r <= fw(q_word.a_num) + fw(q_word.b_num);
        rd_r <= fw(q_word.a_den);
      end
    end
    case (st_r)
      ST_MUL: begin
        rn_r <= an_r * bn_r;
        rd_r <= ad_r * bd_r;
      end
      ST_GCD: begin
        // lcm order keeps original hi/lo; save them in l_r / t_r
        if (cls_r == CL_ADDLCM && t_r == '0 && l_r == '0) begin
          l_r <= hi_r;
        end
      end
      ST_GCD_WAIT: begin
        if (ddone) begin
          if (drem != '0) begin
            hi_r <= lo_r;
            lo_r <= drem;
          end else if (cls_r == CL_ADDLCM) begin
            // hi <- original max, lo keeps the gcd, for the lcm division
            hi_r <= l_r;
          end
        end
      end
      ST_L_MUL: l_r <= dq * t_r;
      ST_S1_MUL: s1_r <= dq * an_r;
      ST_S2_MUL: begin
        rn_r <= s1_r + dq * bn_r;
        rd_r <= l_r;
      end
      ST_SD_DIV: if (ddone) rd_r <= dq;
      ST_Q_DIV: if (ddone) begin rn_r <= dq; rd_r <= W'(1); end
      default: ;
    endcase
    if (st_r == ST_SN_DIV && ddone) rn_r <= dq;
    if (st_r == ST_L_DIV && ddone) t_r <= t_r;
    if (take) begin
      l_r <= slt_ab ? fw(q_word.b_den) : fw(q_word.a_den);
      t_r <= slt_ab ? fw(q_word.a_den) : fw(q_word.b_den);
    end
    if (st_r == ST_DONE && (!ov_r || out_ready)) begin
      on_r  <= (flt_r || (st_r == ST_DONE && 1'b0)) ? '0 : ow(rn_r);
      od_r  <= flt_r ? '0 : ow(rd_r);
      ost_r <= flt_r;
    end
  end

  assign out_valid   = ov_r;
  assign out_res_num = on_r;
  assign out_res_den = od_r;
  assign out_status  = ost_r;
endmodule
`default_nettype wire

### rtl/core/rational_fraction_alu_unit.sv
// Multiply and equal-denominator add finish without the divider.
// Each Euclid step and each later divide runs on one shared divider;
// the 32-bit worst case is the longest Euclid chain plus 3 divides.
// Throughput: one word per back-end run; the back end takes a new word only when idle.
// A 2-entry queue lets the input side take up to two words ahead of the back end.
// Reset: synchronous active-low rst_n clears the queue, sequencer and output valid.
`default_nettype none
`include "rational_fraction_alu_unit_defines.svh"
module rational_fraction_alu_unit #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  rfa_if.sink       in_ch,
  rfa_if.source     out_ch
);
  import rfa_pkg::*;

  // in_ch.data: {op, a_num, a_den, b_num, b_den}; out_ch.data: {res_num, res_den, status}
  logic      q_valid, q_ready;
  fe_word_t  q_word;
  div_ctl_t  dctl;
  logic [FieldW-1:0] rn, rd;
  logic st;

  rfa_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_op(in_ch.data[4*FieldW+1:4*FieldW]),
    .in_a_num(in_ch.data[4*FieldW-1:3*FieldW]),
    .in_a_den(in_ch.data[3*FieldW-1:2*FieldW]),
    .in_b_num(in_ch.data[2*FieldW-1:FieldW]),
    .in_b_den(in_ch.data[FieldW-1:0]),
    .q_valid(q_valid), .q_ready(q_ready), .q_word(q_word)
  );

  // Back end runs Euclid and divides through the shared serial divider.
  rfa_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_ready(q_ready), .q_word(q_word),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_res_num(rn), .out_res_den(rd), .out_status(st), .dctl(dctl)
  );

  assign out_ch.data = {rn, rd, st};

  `RFA_ASSERT_IMP(a_start_idle, dctl.start, !dctl.busy, "divider restarted while busy")
  `RFA_ASSERT_NEXT(a_start_busy, dctl.start, dctl.busy, "divider did not go busy")
  `RFA_ASSERT_IMP(a_err_zero, out_ch.valid && st, rn == '0 && rd == '0, "error result not zero")
endmodule
`default_nettype wire

### tb/tb_rational_fraction_alu_unit.sv
// Self-checking testbench for the signed fraction ALU: directed and random words.
`timescale 1ns / 1ps
`default_nettype none
module tb_rational_fraction_alu_unit;
  import rfa_pkg::*;

  // Input word: opcode and two fractions. Result word: fraction and fault flag.
  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] a_num;
    logic [31:0] a_den;
    logic [31:0] b_num;
    logic [31:0] b_den;
  } frac_in_t;

  typedef struct packed {
    logic [31:0] res_num;
    logic [31:0] res_den;
    logic        status;
  } frac_out_t;

  localparam bit signed [31:0] SMIN = 32'sh8000_0000;
  localparam bit signed [31:0] SMAX = 32'sh7fff_ffff;
  localparam int NUM_ITEMS = 348;

  // Expected fraction results, predicted from each accepted input word.
  class frac_scoreboard;
    frac_out_t pending_q[$];
    int errors;
    int n_results;
    int n_faults;
    int op_count[4];
    bit fault;

    function bit signed [31:0] sdiv(bit signed [31:0] x, bit signed [31:0] y);
      longint mx, my, q;
      if (y == 0) begin
        fault = 1;
        return 0;
      end
      mx = (x < 0) ? -longint'(x) : longint'(x);
      my = (y < 0) ? -longint'(y) : longint'(y);
      q = mx / my;
      if ((x < 0) != (y < 0)) q = -q;
      return q[31:0];
    endfunction

    function bit signed [31:0] srem(bit signed [31:0] x, bit signed [31:0] y);
      longint mx, my, r;
      if (y == 0) begin
        fault = 1;
        return 0;
      end
      mx = (x < 0) ? -longint'(x) : longint'(x);
      my = (y < 0) ? -longint'(y) : longint'(y);
      r = mx % my;
      if (x < 0) r = -r;
      return r[31:0];
    endfunction

    // Euclid on signed values; result keeps the sign of the last divisor.
    function bit signed [31:0] euclid(bit signed [31:0] x, bit signed [31:0] y);
      bit signed [31:0] hi, lo, last;
      int n;
      hi = (x < y) ? y : x;
      lo = (x < y) ? x : y;
      n = 0;
      do begin
        last = lo;
        lo = srem(hi, lo);
        hi = last;
        n++;
      end while (lo != 0 && !fault && n < 200);
      return last;
    endfunction

    function void note_input(frac_in_t w);
      bit signed [31:0] an, ad, bn, bd, rn, rd, hi, lo, g, l, s1, s2;
      frac_out_t e;
      an = w.a_num; ad = w.a_den; bn = w.b_num; bd = w.b_den;
      rn = 0; rd = 0; fault = 0;
      op_count[w.op]++;
      case (op_t'(w.op))
        OP_MUL: begin
          rn = an * bn;
          rd = ad * bd;
        end
        OP_ADD: begin
          if (ad != bd) begin
            hi = (ad < bd) ? bd : ad;
            lo = (ad < bd) ? ad : bd;
            g = euclid(hi, lo);
            l = 0; s1 = 0; s2 = 0;
            if (!fault) l = sdiv(hi, g) * lo;
            if (!fault) s1 = sdiv(l, ad) * an;
            if (!fault) s2 = sdiv(l, bd) * bn;
            rn = s1 + s2;
            rd = l;
          end else begin
            // shared denominator, no division even if it is zero
            rn = an + bn;
            rd = ad;
          end
        end
        OP_SIMP: begin
          g = euclid(an, ad);
          if (!fault) begin
            rn = sdiv(an, g);
            rd = sdiv(ad, g);
          end
        end
        default: begin
          rn = sdiv(an, ad);
          rd = 1;
        end
      endcase
      if (fault) begin
        rn = 0;
        rd = 0;
        n_faults++;
      end
      e.res_num = rn;
      e.res_den = rd;
      e.status = fault;
      pending_q.push_back(e);
    endfunction

    function void check_result(frac_out_t got);
      frac_out_t e;
      n_results++;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word %h", $time, got);
        return;
      end
      e = pending_q.pop_front();
      if (got.res_num !== e.res_num) begin
        errors++;
        $display("%0t: res_num expected %h actual %h", $time, e.res_num, got.res_num);
      end
      if (got.res_den !== e.res_den) begin
        errors++;
        $display("%0t: res_den expected %h actual %h", $time, e.res_den, got.res_den);
      end
      if (got.status !== e.status) begin
        errors++;
        $display("%0t: status expected %b actual %b", $time, e.status, got.status);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  frac_scoreboard sb = new();

  always #1 clk = ~clk;

  rfa_if #(.payload_t(frac_in_t))  in_ch (clk);
  rfa_if #(.payload_t(frac_out_t)) out_ch (clk);

  rational_fraction_alu_unit #(.DATA_WIDTH(32)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  // Receiver stalls: ready redrawn every cycle at the current idle rate.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Monitors: both handshakes sampled at the edge, before any update lands.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) sb.note_input(in_ch.data);
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
  end

  // Hands one word to the block; the sender may idle first.
  task automatic send_word(frac_in_t w);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= w;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_op(op_t op, bit signed [31:0] an, bit signed [31:0] ad,
                         bit signed [31:0] bn, bit signed [31:0] bd);
    frac_in_t w;
    w.op = op; w.a_num = an; w.a_den = ad; w.b_num = bn; w.b_den = bd;
    send_word(w);
  endtask

  // Operand mix: small values (zero included), full range, extremes, multiples.
  function automatic bit signed [31:0] pick_value(bit signed [31:0] base);
    case ($urandom_range(9))
      0, 1, 2: return $signed($urandom_range(40)) - 20;
      3, 4, 5: return $urandom;
      6: begin
        case ($urandom_range(4))
          0: return SMIN;
          1: return SMAX;
          2: return 0;
          3: return 1;
          default: return -1;
        endcase
      end
      default: return base * ($signed($urandom_range(2000)) - 1000);
    endcase
  endfunction

  task automatic send_random();
    bit signed [31:0] base;
    base = $urandom_range(60) + 1;
    send_op(op_t'($urandom_range(3)), pick_value(base), pick_value(base),
            pick_value(base), pick_value(base));
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: each op at the field extremes and every fault path.
    tx_idle_pct = 21;
    rx_idle_pct = 85;
    send_op(OP_MUL, 3, 4, -5, 7);
    send_op(OP_MUL, SMIN, SMAX, -1, SMIN);
    send_op(OP_MUL, SMAX, -1, SMAX, 0);
    send_op(OP_ADD, 1, 6, 1, 4);
    send_op(OP_ADD, 5, 0, -7, 0);        // equal zero denominators, no divide
    send_op(OP_ADD, SMAX, 9, SMAX, 9);   // shared denominator, sum wraps
    send_op(OP_ADD, 1, 0, 2, 5);         // zero denominator faults in Euclid
    send_op(OP_ADD, 3, -6, 2, 4);        // negative gcd
    send_op(OP_ADD, 1, SMIN, 1, SMAX);
    send_op(OP_ADD, 1, SMIN, 1, -1);     // most negative by -1
    send_op(OP_SIMP, 12, 18, 0, 0);
    send_op(OP_SIMP, -12, 18, 0, 0);
    send_op(OP_SIMP, 0, 7, 0, 0);        // zero numerator becomes the divisor
    send_op(OP_SIMP, 7, 0, 0, 0);
    send_op(OP_SIMP, 0, 0, 0, 0);
    send_op(OP_SIMP, SMIN, -1, SMAX, SMIN);
    send_op(OP_SIMP, SMAX, SMIN, 0, 0);
    send_op(OP_QUOT, 7, 2, 0, 0);
    send_op(OP_QUOT, -7, 2, 0, 0);
    send_op(OP_QUOT, 7, 0, 0, 0);
    send_op(OP_QUOT, SMIN, -1, 0, 0);
    send_op(OP_QUOT, SMAX, SMIN, -1, -1);

    // Random: three idle profiles, one third of the words each.
    for (int i = 0; i < NUM_ITEMS; i++) begin
      if (i == NUM_ITEMS / 3) begin
        tx_idle_pct = 85;
        rx_idle_pct = 21;
      end else if (i == 2 * NUM_ITEMS / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      send_random();
    end
    in_ch.valid <= 1'b0;

    // Wait until the monitor has logged the last accepted word.
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Covered %0d results: mul %0d, add %0d, simplify %0d, quotient %0d.",
             sb.n_results, sb.op_count[0], sb.op_count[1], sb.op_count[2],
             sb.op_count[3]);
    $display("Fault results: %0d; idle profiles 21/85, 85/21 and none.", sb.n_faults);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Hang guard: well above the slowest Euclid chains under heavy stalls.
  initial begin
    #8000000;
    $display("DONE: errors detected");
    $finish;
  end
endmodule
`default_nettype wire
